// ===== rtl/core/cwd_pkg.sv =====
// Shared constants, payload structs, cell interface types and state codes for the column dispatcher.
package cwd_pkg;

    // Sizing of the column store and the worker table
    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_WORKERS = 64;

    localparam int COL_W    = $clog2(MAX_COLUMNS);
    localparam int WORKER_W = $clog2(MAX_WORKERS);
    localparam int COUNT_W  = 11;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;

    localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
    localparam int COUNT_RESET = 1024;

    // Search limit can never exceed the store depth nor the count range
    localparam int LIMIT_CAP = (MAX_COLUMNS > COUNT_MAX) ? COUNT_MAX : MAX_COLUMNS;

    // Each cell of the search chain owns one group of columns
    localparam int GROUP      = 64;
    localparam int LOCAL_W    = $clog2(GROUP);
    localparam int CELL_COUNT = (MAX_COLUMNS + GROUP - 1) / GROUP;
    localparam int CELL_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int FULL_W     = CELL_W + LOCAL_W;
    localparam int CMP_W      = (FULL_W > COUNT_W) ? FULL_W : COUNT_W;

    // Event codes
    localparam logic [MODE_W-1:0] MODE_JOIN  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DONE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LEAVE = 2'd2;

    // Result codes
    localparam logic [STATUS_W-1:0] STATUS_ASSIGNED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED   = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [WORKER_W-1:0] worker_slot;
    } cwd_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COL_W-1:0]    assigned_column;
        logic [COUNT_W-1:0]  worker_completed;
        logic [COUNT_W-1:0]  total_completed;
        logic                finished;
    } cwd_out_t;

    // Search token handed from cell to cell
    typedef struct packed {
        logic              active;
        logic              found;
        logic [FULL_W-1:0] column;
    } cwd_wave_t;

    // Broadcast release of one column back to idle
    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] column;
    } cwd_clear_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SEARCH,
        ST_RESULT
    } cwd_state_t;

    // Saturating increment of a completion count
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        logic [COUNT_W-1:0] r;
        if (v == COUNT_W'(COUNT_MAX))
        begin
            r = v;
        end
        else
        begin
            r = v + 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/cwd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/cwd_cell.sv =====
// One cell of the search chain: busy bits of a column group and a stage of the search token.
module cwd_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [cwd_pkg::CELL_W-1:0]     base,
    input  logic [cwd_pkg::COUNT_W-1:0]    limit,
    input  cwd_pkg::cwd_clear_t            clear,
    input  cwd_pkg::cwd_wave_t             wave_in,
    output cwd_pkg::cwd_wave_t             wave_out
);

    logic [cwd_pkg::GROUP-1:0]   busy_reg;
    logic [cwd_pkg::GROUP-1:0]   busy_next;
    logic [cwd_pkg::GROUP-1:0]   eligible;
    logic [cwd_pkg::GROUP-1:0]   free_bits;
    logic                        hit;
    logic [cwd_pkg::LOCAL_W-1:0] hit_idx;
    logic [cwd_pkg::FULL_W-1:0]  clr_full;
    logic                        clr_here;
    cwd_pkg::cwd_wave_t          wave_reg;
    cwd_pkg::cwd_wave_t          wave_next;

    // Mark columns below the search limit
    always_comb
    begin
        for (int b = 0; b < cwd_pkg::GROUP; b++)
        begin
            eligible[b] = (cwd_pkg::CMP_W'({base, cwd_pkg::LOCAL_W'(b)})
                           < cwd_pkg::CMP_W'(limit));
        end
    end

    assign free_bits = ~busy_reg & eligible;
    assign hit       = |free_bits;

    // Pick the lowest free column of the group
    always_comb
    begin
        hit_idx = '0;
        for (int b = cwd_pkg::GROUP - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                hit_idx = cwd_pkg::LOCAL_W'(b);
            end
        end
    end

    assign clr_full = cwd_pkg::FULL_W'(clear.column);
    assign clr_here = clear.en && (clr_full[cwd_pkg::FULL_W-1:cwd_pkg::LOCAL_W] == base);

    // Claim a column for a passing token, release a column on request
    always_comb
    begin
        busy_next = busy_reg;
        wave_next = wave_in;
        if (clr_here)
        begin
            busy_next[clr_full[cwd_pkg::LOCAL_W-1:0]] = 1'b0;
        end
        if (wave_in.active && !wave_in.found && hit)
        begin
            busy_next[hit_idx] = 1'b1;
            wave_next.found    = 1'b1;
            wave_next.column   = {base, hit_idx};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
            wave_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            wave_reg <= wave_next;
        end
    end

    assign wave_out = wave_reg;

endmodule

// ===== rtl/core/column_work_dispatcher_top.sv =====
// Flow: an accepted event is evaluated in ST_EVAL; release or ignored events go straight to
// ST_RESULT, while a column search first walks the token through the cell chain in ST_SEARCH.
// Throughput: one event at a time; the next transaction is taken the cycle after the result
// is registered, and a stalled output holds the block in ST_RESULT until the result is taken.
// Reset: asynchronous active-low; all columns idle, no worker holds a column,
// all completion counts zero, column_count back to 1024, no clearing pass needed.
module column_work_dispatcher_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  cwd_pkg::cwd_in_t            in_item,
    output logic                        out_valid,
    input  logic                        out_stall,
    output cwd_pkg::cwd_out_t           out_item,
    input  logic                        cfg_we,
    input  logic [cwd_pkg::COUNT_W-1:0] cfg_wdata
);

    cwd_pkg::cwd_state_t             state_reg;
    cwd_pkg::cwd_state_t             state_next;
    logic [cwd_pkg::MODE_W-1:0]      mode_reg;
    logic [cwd_pkg::WORKER_W-1:0]    slot_reg;
    logic [cwd_pkg::COUNT_W-1:0]     column_count_reg;
    logic [cwd_pkg::MAX_WORKERS-1:0] has_column_reg;
    logic [cwd_pkg::MAX_WORKERS-1:0] has_column_next;
    logic [cwd_pkg::MAX_WORKERS-1:0] cnt_valid_reg;
    logic [cwd_pkg::COUNT_W-1:0]     total_reg;
    logic [cwd_pkg::COUNT_W-1:0]     wdone_reg;
    logic [cwd_pkg::STATUS_W-1:0]    status_reg;
    logic [cwd_pkg::COL_W-1:0]       col_reg;
    logic                            out_valid_reg;
    cwd_pkg::cwd_out_t               out_reg;

    logic                            accept;
    logic                            start_search;
    logic                            count_we;
    logic                            col_we;
    logic                            search_end;
    logic                            load_out;
    logic                            has_cur;
    logic [cwd_pkg::COUNT_W-1:0]     cnt_rdata;
    logic [cwd_pkg::COUNT_W-1:0]     cnt_cur;
    logic [cwd_pkg::COUNT_W-1:0]     cnt_inc;
    logic [cwd_pkg::COL_W-1:0]       col_rdata;
    logic [cwd_pkg::WORKER_W-1:0]    rd_slot;
    logic [cwd_pkg::COUNT_W-1:0]     limit;
    cwd_pkg::cwd_clear_t             clear;
    cwd_pkg::cwd_wave_t              wave_chain [cwd_pkg::CELL_COUNT+1];

    // Worker lookups
    assign has_cur = has_column_reg[slot_reg];
    assign cnt_cur = cnt_valid_reg[slot_reg] ? cnt_rdata : '0;
    assign cnt_inc = cwd_pkg::sat_inc(cnt_cur);
    assign rd_slot = (state_reg == cwd_pkg::ST_IDLE) ? in_item.worker_slot : slot_reg;

    // Clamp the search limit to the store depth
    assign limit = (column_count_reg > cwd_pkg::COUNT_W'(cwd_pkg::LIMIT_CAP))
                   ? cwd_pkg::COUNT_W'(cwd_pkg::LIMIT_CAP) : column_count_reg;

    assign search_end = wave_chain[cwd_pkg::CELL_COUNT].active;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cwd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cwd_pkg::ST_EVAL;
                end
            end
            cwd_pkg::ST_EVAL:
            begin
                state_next = start_search ? cwd_pkg::ST_SEARCH : cwd_pkg::ST_RESULT;
            end
            cwd_pkg::ST_SEARCH:
            begin
                if (search_end)
                begin
                    state_next = cwd_pkg::ST_RESULT;
                end
            end
            cwd_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = cwd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cwd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_stall     = 1'b1;
        accept       = 1'b0;
        start_search = 1'b0;
        count_we     = 1'b0;
        col_we       = 1'b0;
        load_out     = 1'b0;
        clear.en     = 1'b0;
        clear.column = col_rdata;
        case (state_reg)
            cwd_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                accept   = in_valid;
            end
            cwd_pkg::ST_EVAL:
            begin
                case (mode_reg)
                    cwd_pkg::MODE_JOIN:
                    begin
                        start_search = !has_cur;
                    end
                    cwd_pkg::MODE_DONE:
                    begin
                        start_search = has_cur;
                        count_we     = has_cur;
                    end
                    cwd_pkg::MODE_LEAVE:
                    begin
                        clear.en = has_cur;
                    end
                    default:
                    begin
                        start_search = 1'b0;
                    end
                endcase
            end
            cwd_pkg::ST_SEARCH:
            begin
                col_we = search_end && wave_chain[cwd_pkg::CELL_COUNT].found;
            end
            cwd_pkg::ST_RESULT:
            begin
                load_out = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Inject the search token into the first cell
    assign wave_chain[0] = {start_search, 1'b0, cwd_pkg::FULL_W'(0)};

    // Chain of column cells
    for (genvar g = 0; g < cwd_pkg::CELL_COUNT; g++)
    begin : g_cell
        cwd_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .base     (cwd_pkg::CELL_W'(g)),
            .limit    (limit),
            .clear    (clear),
            .wave_in  (wave_chain[g]),
            .wave_out (wave_chain[g+1])
        );
    end

    // Column held by each worker
    cwd_ram #(
        .WIDTH (cwd_pkg::COL_W),
        .DEPTH (cwd_pkg::MAX_WORKERS)
    ) u_col_ram (
        .clk   (clk),
        .we    (col_we),
        .waddr (slot_reg),
        .wdata (cwd_pkg::COL_W'(wave_chain[cwd_pkg::CELL_COUNT].column)),
        .raddr (rd_slot),
        .rdata (col_rdata)
    );

    // Completion count of each worker
    cwd_ram #(
        .WIDTH (cwd_pkg::COUNT_W),
        .DEPTH (cwd_pkg::MAX_WORKERS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (count_we),
        .waddr (slot_reg),
        .wdata (cnt_inc),
        .raddr (rd_slot),
        .rdata (cnt_rdata)
    );

    // Update worker ownership flags
    always_comb
    begin
        has_column_next = has_column_reg;
        if (clear.en)
        begin
            has_column_next[slot_reg] = 1'b0;
        end
        if (state_reg == cwd_pkg::ST_SEARCH && search_end)
        begin
            has_column_next[slot_reg] = wave_chain[cwd_pkg::CELL_COUNT].found;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= cwd_pkg::ST_IDLE;
            column_count_reg <= cwd_pkg::COUNT_W'(cwd_pkg::COUNT_RESET);
            has_column_reg   <= '0;
            cnt_valid_reg    <= '0;
            total_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            has_column_reg <= has_column_next;
            if (cfg_we)
            begin
                column_count_reg <= cfg_wdata;
            end
            if (count_we)
            begin
                cnt_valid_reg[slot_reg] <= 1'b1;
                total_reg               <= cwd_pkg::sat_inc(total_reg);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Transaction payload and result fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= in_item.mode;
            slot_reg <= in_item.worker_slot;
        end
        if (state_reg == cwd_pkg::ST_EVAL)
        begin
            status_reg <= cwd_pkg::STATUS_IGNORED;
            col_reg    <= '0;
            wdone_reg  <= count_we ? cnt_inc : cnt_cur;
        end
        if (state_reg == cwd_pkg::ST_SEARCH && search_end)
        begin
            if (wave_chain[cwd_pkg::CELL_COUNT].found)
            begin
                status_reg <= cwd_pkg::STATUS_ASSIGNED;
                col_reg    <= cwd_pkg::COL_W'(wave_chain[cwd_pkg::CELL_COUNT].column);
            end
            else
            begin
                status_reg <= cwd_pkg::STATUS_EXHAUSTED;
                col_reg    <= '0;
            end
        end
        if (load_out)
        begin
            out_reg.status           <= status_reg;
            out_reg.assigned_column  <= col_reg;
            out_reg.worker_completed <= wdone_reg;
            out_reg.total_completed  <= total_reg;
            out_reg.finished         <= (total_reg == column_count_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // The token leaves the chain only while a search is pending
    a_wave_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        search_end |-> (state_reg == cwd_pkg::ST_SEARCH))
        else $error("search token left the cell chain outside a search");

    // A successful search leaves the worker holding a column
    a_found_owns: assert property (@(posedge clk) disable iff (!rst_n)
        (col_we) |=> has_column_reg[slot_reg])
        else $error("assigned column not recorded for worker");

    // A release never starts a search
    a_leave_no_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cwd_pkg::ST_EVAL && mode_reg == cwd_pkg::MODE_LEAVE)
        |=> (state_reg == cwd_pkg::ST_RESULT))
        else $error("release event entered the search");

    // Results are loaded only when the output register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !load_out)
        else $error("pending result overwritten");

endmodule
